// File: rtl/ffsa_pkg.sv
// Shared constants for the first-fit segment allocator: request and result
// codes, parameter defaults and the pool size after reset. No dependencies.
package ffsa_pkg;

  localparam int DEF_MAX_SEGMENTS = 32;
  localparam int DEF_MAX_HANDLES  = 4096;
  localparam int DEF_ADDR_BITS    = 24;
  localparam int POOL_RESET       = 65536;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_LIST  = 2'd2;

  localparam logic [2:0] ST_ALLOC_OK   = 3'd0;
  localparam logic [2:0] ST_ALLOC_FAIL = 3'd1;
  localparam logic [2:0] ST_FREE_OK    = 3'd2;
  localparam logic [2:0] ST_FREE_FAIL  = 3'd3;
  localparam logic [2:0] ST_FREE_SEG   = 3'd4;
  localparam logic [2:0] ST_NONE_FREE  = 3'd5;

endpackage

// File: rtl/first_fit_segment_allocator.sv
// First-fit allocator over [0, pool_size): segment list and handle table in
// synchronous memories with registered reads. One request is worked on at a time:
// an allocate request walks the list entry by entry, a list request visits every
// entry, and a waiting result holds the allocator until it is taken. Reset and a
// pool size write take effect at once: entry zero reads as [0, pool_size) until
// first written, and handles above the issue counter read as invalid, so there is
// no clear pass. Depends on ffsa_pkg.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_HANDLES  = DEF_MAX_HANDLES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ADDR_BITS-1:0]           cfg_pool_size,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [ADDR_BITS-1:0]           in_alloc_size,
  input  logic [$clog2(MAX_HANDLES)-1:0] in_free_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [ADDR_BITS-1:0]           out_block_address,
  output logic [ADDR_BITS-1:0]           out_segment_end,
  output logic [$clog2(MAX_HANDLES)-1:0] out_issued_handle,
  output logic                           out_last_of_run
);

  localparam int SEG_W  = $clog2(MAX_SEGMENTS);
  localparam int LINK_W = $clog2(MAX_SEGMENTS + 1);
  localparam int HND_W  = $clog2(MAX_HANDLES);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_SEGMENTS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_REQ = 4'd1;
  localparam logic [3:0] S_A_CHK = 4'd2;
  localparam logic [3:0] S_A_S1  = 4'd3;
  localparam logic [3:0] S_A_S2  = 4'd4;
  localparam logic [3:0] S_F_H   = 4'd5;
  localparam logic [3:0] S_F_T   = 4'd6;
  localparam logic [3:0] S_F_N   = 4'd7;
  localparam logic [3:0] S_F_NN  = 4'd8;
  localparam logic [3:0] S_F_P   = 4'd9;
  localparam logic [3:0] S_F_PV  = 4'd10;
  localparam logic [3:0] S_F_PN  = 4'd11;
  localparam logic [3:0] S_L_REQ = 4'd12;
  localparam logic [3:0] S_L_CHK = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  typedef struct packed {
    logic [ADDR_BITS-1:0] st;
    logic [ADDR_BITS-1:0] en;
    logic                 used;
    logic [LINK_W-1:0]    nx;
    logic [LINK_W-1:0]    pv;
  } seg_t;

  typedef struct packed {
    logic             ok;
    logic [SEG_W-1:0] seg;
  } hent_t;

  // memories
  seg_t  seg_mem [MAX_SEGMENTS];
  hent_t hnd_mem [MAX_HANDLES];

  logic             seg_re, seg_we;
  logic [SEG_W-1:0] seg_ra, seg_wa;
  seg_t             seg_wd, seg_rd_r, seg_q, seg_init;
  logic             q0_r;
  logic             hnd_re, hnd_we;
  logic [HND_W-1:0] hnd_ra, hnd_wa;
  hent_t            hnd_wd, hnd_q_r;

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    if (seg_re) begin
      seg_rd_r <= seg_mem[seg_ra];
    end
    if (hnd_we) begin
      hnd_mem[hnd_wa] <= hnd_wd;
    end
    if (hnd_re) begin
      hnd_q_r <= hnd_mem[hnd_ra];
    end
  end

  // control and datapath registers
  logic [3:0]            state_r, state_nxt;
  logic [LINK_W-1:0]     p_r, p_nxt;
  seg_t                  cur_r, cur_nxt;
  logic [SEG_W-1:0]      curi_r, curi_nxt;
  logic [SEG_W-1:0]      aux_r, aux_nxt;
  logic [ADDR_BITS-1:0]  size_r, size_nxt;
  logic [HND_W-1:0]      hndl_r, hndl_nxt;
  logic [HND_W-1:0]      cnt_r, cnt_nxt;
  logic [LINK_W-1:0]     head_r, head_nxt;
  logic [MAX_SEGMENTS-1:0] spare_r, spare_nxt;
  logic [ADDR_BITS-1:0]  pool_r, pool_nxt;
  logic                  fresh0_r, fresh0_nxt;
  logic                  pend_r, pend_nxt;
  logic [2:0]            res_st_r, res_st_nxt;
  logic [ADDR_BITS-1:0]  res_addr_r, res_addr_nxt;
  logic [ADDR_BITS-1:0]  res_end_r, res_end_nxt;
  logic [HND_W-1:0]      res_hnd_r, res_hnd_nxt;

  logic                  out_valid_r;
  logic [2:0]            out_st_r;
  logic [ADDR_BITS-1:0]  out_addr_r, out_end_r;
  logic [HND_W-1:0]      out_hnd_r;
  logic                  out_last_r;
  logic                  out_load, out_last_nxt, out_free;
  logic                  in_fire, cfg_fire;

  assign seg_init = '{st: '0, en: pool_r, used: 1'b0, nx: NIL, pv: NIL};
  assign seg_q    = q0_r ? seg_init : seg_rd_r;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    seg_t                 s;
    logic [ADDR_BITS-1:0] len;
    logic [SEG_W-1:0]     fresh;
    logic                 bad_h;
    s     = seg_q;
    len   = seg_q.en - seg_q.st;
    fresh = '0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (spare_r[i]) begin
        fresh = SEG_W'(i);
      end
    end
    bad_h = (in_free_handle == '0) || (in_free_handle > cnt_r) ||
            ({1'b0, in_free_handle} >= (HND_W + 1)'(MAX_HANDLES));

    state_nxt    = state_r;
    p_nxt        = p_r;
    cur_nxt      = cur_r;
    curi_nxt     = curi_r;
    aux_nxt      = aux_r;
    size_nxt     = size_r;
    hndl_nxt     = hndl_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    spare_nxt    = spare_r;
    pool_nxt     = pool_r;
    fresh0_nxt   = fresh0_r;
    pend_nxt     = pend_r;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    res_end_nxt  = res_end_r;
    res_hnd_nxt  = res_hnd_r;
    seg_re = 1'b0; seg_ra = '0;
    seg_we = 1'b0; seg_wa = '0; seg_wd = seg_q;
    hnd_re = 1'b0; hnd_ra = '0;
    hnd_we = 1'b0; hnd_wa = hndl_r; hnd_wd = '{ok: 1'b0, seg: '0};
    out_load     = 1'b0;
    out_last_nxt = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_fire) begin
          pool_nxt   = cfg_pool_size;
          fresh0_nxt = 1'b1;
          spare_nxt  = {{(MAX_SEGMENTS-1){1'b1}}, 1'b0};
          head_nxt   = '0;
          cnt_nxt    = '0;
        end else if (in_fire) begin
          res_addr_nxt = '0;
          res_end_nxt  = '0;
          res_hnd_nxt  = '0;
          unique case (in_req_type)
            REQ_ALLOC: begin
              res_st_nxt = ST_ALLOC_FAIL;
              if (cnt_r >= HND_W'(MAX_HANDLES - 1)) begin
                state_nxt = S_EMIT;
              end else begin
                cnt_nxt     = cnt_r + 1'b1;
                hndl_nxt    = cnt_r + 1'b1;
                res_hnd_nxt = cnt_r + 1'b1;
                size_nxt    = in_alloc_size;
                if (in_alloc_size == '0) begin
                  hnd_we    = 1'b1;
                  hnd_wa    = cnt_r + 1'b1;
                  state_nxt = S_EMIT;
                end else begin
                  p_nxt     = head_r;
                  state_nxt = S_A_REQ;
                end
              end
            end
            REQ_FREE: begin
              if (bad_h) begin
                res_st_nxt = ST_FREE_FAIL;
                state_nxt  = S_EMIT;
              end else begin
                hnd_re     = 1'b1;
                hnd_ra     = in_free_handle;
                hndl_nxt   = in_free_handle;
                res_st_nxt = ST_FREE_OK;
                state_nxt  = S_F_H;
              end
            end
            REQ_LIST: begin
              p_nxt     = head_r;
              pend_nxt  = 1'b0;
              state_nxt = S_L_REQ;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_A_REQ: begin
        if (p_r == NIL) begin
          hnd_we     = 1'b1;
          res_st_nxt = ST_ALLOC_FAIL;
          state_nxt  = S_EMIT;
        end else begin
          seg_re    = 1'b1;
          seg_ra    = p_r[SEG_W-1:0];
          state_nxt = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (!s.used && len >= size_r) begin
          res_addr_nxt = s.st;
          if (len == size_r) begin
            seg_we      = 1'b1;
            seg_wa      = p_r[SEG_W-1:0];
            seg_wd      = s;
            seg_wd.used = 1'b1;
            hnd_we      = 1'b1;
            hnd_wd      = '{ok: 1'b1, seg: p_r[SEG_W-1:0]};
            res_st_nxt  = ST_ALLOC_OK;
            state_nxt   = S_EMIT;
          end else if (spare_r == '0) begin
            hnd_we     = 1'b1;
            res_addr_nxt = '0;
            res_st_nxt = ST_ALLOC_FAIL;
            state_nxt  = S_EMIT;
          end else begin
            // split off the front into a spare entry
            spare_nxt[fresh] = 1'b0;
            aux_nxt   = fresh;
            cur_nxt   = '{st: s.st, en: s.st + size_r, used: 1'b1, nx: p_r, pv: s.pv};
            seg_we    = 1'b1;
            seg_wa    = p_r[SEG_W-1:0];
            seg_wd    = s;
            seg_wd.st = s.st + size_r;
            seg_wd.pv = LINK_W'(fresh);
            seg_re    = (s.pv != NIL);
            seg_ra    = s.pv[SEG_W-1:0];
            hnd_we    = 1'b1;
            hnd_wd    = '{ok: 1'b1, seg: fresh};
            res_st_nxt = ST_ALLOC_OK;
            state_nxt  = S_A_S1;
          end
        end else begin
          p_nxt     = s.nx;
          state_nxt = S_A_REQ;
        end
      end

      S_A_S1: begin
        seg_we = 1'b1;
        seg_wa = aux_r;
        seg_wd = cur_r;
        if (cur_r.pv != NIL) begin
          state_nxt = S_A_S2;
        end else begin
          head_nxt  = LINK_W'(aux_r);
          state_nxt = S_EMIT;
        end
      end

      S_A_S2: begin
        seg_we    = 1'b1;
        seg_wa    = cur_r.pv[SEG_W-1:0];
        seg_wd    = s;
        seg_wd.nx = LINK_W'(aux_r);
        state_nxt = S_EMIT;
      end

      S_F_H: begin
        if (!hnd_q_r.ok) begin
          res_st_nxt = ST_FREE_FAIL;
          state_nxt  = S_EMIT;
        end else begin
          hnd_we    = 1'b1;
          hnd_wd    = '{ok: 1'b0, seg: hnd_q_r.seg};
          curi_nxt  = hnd_q_r.seg;
          seg_re    = 1'b1;
          seg_ra    = hnd_q_r.seg;
          state_nxt = S_F_T;
        end
      end

      S_F_T: begin
        cur_nxt      = s;
        cur_nxt.used = 1'b0;
        if (s.nx != NIL) begin
          seg_re    = 1'b1;
          seg_ra    = s.nx[SEG_W-1:0];
          state_nxt = S_F_N;
        end else begin
          state_nxt = S_F_P;
        end
      end

      S_F_N: begin
        state_nxt = S_F_P;
        if (!s.used) begin
          // absorb the free successor
          spare_nxt[cur_r.nx[SEG_W-1:0]] = 1'b1;
          cur_nxt.en = s.en;
          cur_nxt.nx = s.nx;
          if (s.nx != NIL) begin
            seg_re    = 1'b1;
            seg_ra    = s.nx[SEG_W-1:0];
            state_nxt = S_F_NN;
          end
        end
      end

      S_F_NN: begin
        seg_we    = 1'b1;
        seg_wa    = cur_r.nx[SEG_W-1:0];
        seg_wd    = s;
        seg_wd.pv = LINK_W'(curi_r);
        state_nxt = S_F_P;
      end

      S_F_P: begin
        if (cur_r.pv != NIL) begin
          seg_re    = 1'b1;
          seg_ra    = cur_r.pv[SEG_W-1:0];
          state_nxt = S_F_PV;
        end else begin
          seg_we    = 1'b1;
          seg_wa    = curi_r;
          seg_wd    = cur_r;
          state_nxt = S_EMIT;
        end
      end

      S_F_PV: begin
        state_nxt = S_EMIT;
        if (!s.used) begin
          // fold this segment into the free predecessor
          spare_nxt[curi_r] = 1'b1;
          aux_nxt   = cur_r.pv[SEG_W-1:0];
          seg_we    = 1'b1;
          seg_wa    = cur_r.pv[SEG_W-1:0];
          seg_wd    = s;
          seg_wd.en = cur_r.en;
          seg_wd.nx = cur_r.nx;
          if (cur_r.nx != NIL) begin
            seg_re    = 1'b1;
            seg_ra    = cur_r.nx[SEG_W-1:0];
            state_nxt = S_F_PN;
          end
        end else begin
          seg_we = 1'b1;
          seg_wa = curi_r;
          seg_wd = cur_r;
        end
      end

      S_F_PN: begin
        seg_we    = 1'b1;
        seg_wa    = cur_r.nx[SEG_W-1:0];
        seg_wd    = s;
        seg_wd.pv = LINK_W'(aux_r);
        state_nxt = S_EMIT;
      end

      S_L_REQ: begin
        if (p_r == NIL) begin
          if (!pend_r) begin
            res_st_nxt = ST_NONE_FREE;
          end
          state_nxt = S_EMIT;
        end else begin
          seg_re    = 1'b1;
          seg_ra    = p_r[SEG_W-1:0];
          state_nxt = S_L_CHK;
        end
      end

      S_L_CHK: begin
        if (s.used) begin
          p_nxt     = s.nx;
          state_nxt = S_L_REQ;
        end else if (!pend_r || out_free) begin
          // hand out the held segment, then hold this one
          out_load     = pend_r;
          out_last_nxt = 1'b0;
          pend_nxt     = 1'b1;
          res_st_nxt   = ST_FREE_SEG;
          res_addr_nxt = s.st;
          res_end_nxt  = s.en;
          p_nxt        = s.nx;
          state_nxt    = S_L_REQ;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (seg_we && seg_wa == '0) begin
      fresh0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      head_r   <= '0;
      spare_r  <= {{(MAX_SEGMENTS-1){1'b1}}, 1'b0};
      pool_r   <= ADDR_BITS'(POOL_RESET);
      fresh0_r <= 1'b1;
      pend_r   <= 1'b0;
      q0_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      spare_r  <= spare_nxt;
      pool_r   <= pool_nxt;
      fresh0_r <= fresh0_nxt;
      pend_r   <= pend_nxt;
      if (seg_re) begin
        q0_r <= fresh0_r && (seg_ra == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    cur_r      <= cur_nxt;
    curi_r     <= curi_nxt;
    aux_r      <= aux_nxt;
    size_r     <= size_nxt;
    hndl_r     <= hndl_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    res_end_r  <= res_end_nxt;
    res_hnd_r  <= res_hnd_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_st_r   <= res_st_r;
      out_addr_r <= res_addr_r;
      out_end_r  <= res_end_r;
      out_hnd_r  <= res_hnd_r;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_block_address = out_addr_r;
  assign out_segment_end   = out_end_r;
  assign out_issued_handle = out_hnd_r;
  assign out_last_of_run   = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HND_W'(MAX_HANDLES - 1))
    else $error("handle counter past its limit");

  a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    !spare_r[head_r[SEG_W-1:0]])
    else $error("list head points at a spare entry");

  a_cfg_init: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> (head_r == '0) && (cnt_r == '0) && fresh0_r)
    else $error("pool size write did not reinitialize");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req_type != REQ_ALLOC) && (in_req_type != REQ_FREE) &&
    (in_req_type != REQ_LIST) |=> (state_r == S_IDLE))
    else $error("unknown request left idle");

endmodule

// File: tb/sv/tb_first_fit_segment_allocator.sv
// Self-checking testbench for first_fit_segment_allocator: a clocked driver and
// monitor around a behavioral predictor of the segment list and handle table.
// Depends on ffsa_pkg and the allocator RTL.
module tb_first_fit_segment_allocator;
  import ffsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = DEF_MAX_SEGMENTS;
  localparam int NHND = DEF_MAX_HANDLES;
  localparam int NIL  = NSEG;

  typedef struct {
    logic [1:0]  kind;
    logic [23:0] size;
    logic [11:0] handle;
  } alloc_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [23:0] addr;
    logic [23:0] seg_end;
    logic [11:0] handle;
    logic        last;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_pool_size = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [23:0] in_alloc_size = '0;
  logic [11:0] in_free_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [23:0] out_block_address;
  logic [23:0] out_segment_end;
  logic [11:0] out_issued_handle;
  logic        out_last_of_run;

  first_fit_segment_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_size(cfg_pool_size),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_alloc_size(in_alloc_size), .in_free_handle(in_free_handle),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_block_address(out_block_address), .out_segment_end(out_segment_end),
    .out_issued_handle(out_issued_handle), .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned pool_len;
  int unsigned sg_lo [NSEG];
  int unsigned sg_hi [NSEG];
  bit          sg_busy [NSEG];
  int unsigned sg_nxt [NSEG];
  int unsigned sg_prv [NSEG];
  bit          sg_spare [NSEG];
  int unsigned head_idx;
  bit          hnd_live [NHND];
  int unsigned hnd_seg [NHND];
  int unsigned hnd_count;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int mismatches = 0;
  int rsp_seen = 0;
  int reqs_taken = 0;
  bit in_acc = 1'b0;
  bit quiet = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int gen_issued;

  function automatic void reset_pool(int unsigned len);
    pool_len = len & 24'hFFFFFF;
    for (int i = 0; i < NSEG; i++) begin
      sg_lo[i] = 0; sg_hi[i] = 0; sg_busy[i] = 0;
      sg_nxt[i] = NIL; sg_prv[i] = NIL; sg_spare[i] = (i != 0);
    end
    sg_hi[0] = pool_len;
    head_idx = 0;
    for (int i = 0; i < NHND; i++) begin
      hnd_live[i] = 0;
      hnd_seg[i] = 0;
    end
    hnd_count = 0;
  endfunction

  function automatic void push_rsp(logic [2:0] st, int unsigned a, int unsigned e,
                                   int unsigned h, bit last);
    alloc_rsp_t r;
    r.status = st; r.addr = a[23:0]; r.seg_end = e[23:0]; r.handle = h[11:0];
    r.last = last;
    expected_rsps.push_back(r);
  endfunction

  function automatic void merge_into(int unsigned a, int unsigned b);
    int unsigned n;
    n = sg_nxt[b];
    if (n < NSEG) sg_prv[n] = a;
    sg_nxt[a] = n;
    sg_hi[a] = sg_hi[b];
    sg_spare[b] = 1; sg_busy[b] = 0; sg_nxt[b] = NIL; sg_prv[b] = NIL;
  endfunction

  // returns the segment holding the new block, or NIL
  function automatic int unsigned first_fit(int unsigned size);
    int unsigned p, steps, fresh, pv;
    p = head_idx;
    steps = 0;
    fresh = NIL;
    if (size == 0) return NIL;
    while (p < NSEG && steps < NSEG) begin
      if (!sg_busy[p] && sg_hi[p] - sg_lo[p] >= size) break;
      p = sg_nxt[p];
      steps++;
    end
    if (p >= NSEG || steps >= NSEG) return NIL;
    if (sg_hi[p] - sg_lo[p] == size) begin
      sg_busy[p] = 1;
      return p;
    end
    for (int s = 0; s < NSEG; s++)
      if (sg_spare[s] && fresh == NIL) fresh = s;
    if (fresh >= NSEG) return NIL;
    sg_spare[fresh] = 0;
    sg_lo[fresh] = sg_lo[p];
    sg_hi[fresh] = sg_lo[p] + size;
    sg_busy[fresh] = 1;
    pv = sg_prv[p];
    sg_prv[fresh] = pv;
    if (pv < NSEG) sg_nxt[pv] = fresh;
    else head_idx = fresh;
    sg_prv[p] = fresh;
    sg_nxt[fresh] = p;
    sg_lo[p] = sg_lo[p] + size;
    return fresh;
  endfunction

  function automatic void predict_request(alloc_req_t q);
    int unsigned seg, t, n, pv, p, steps, k;
    case (q.kind)
      REQ_ALLOC: begin
        if (hnd_count >= NHND - 1) begin
          push_rsp(ST_ALLOC_FAIL, 0, 0, 0, 1);
        end else begin
          hnd_count++;
          seg = first_fit(q.size);
          if (seg >= NSEG) begin
            hnd_live[hnd_count] = 0;
            push_rsp(ST_ALLOC_FAIL, 0, 0, hnd_count, 1);
          end else begin
            hnd_live[hnd_count] = 1;
            hnd_seg[hnd_count] = seg;
            push_rsp(ST_ALLOC_OK, sg_lo[seg], 0, hnd_count, 1);
          end
        end
      end
      REQ_FREE: begin
        if (!hnd_live[q.handle]) begin
          push_rsp(ST_FREE_FAIL, 0, 0, 0, 1);
        end else begin
          t = hnd_seg[q.handle];
          hnd_live[q.handle] = 0;
          sg_busy[t] = 0;
          n = sg_nxt[t];
          if (n < NSEG && !sg_busy[n]) merge_into(t, n);
          pv = sg_prv[t];
          if (pv < NSEG && !sg_busy[pv]) merge_into(pv, t);
          push_rsp(ST_FREE_OK, 0, 0, 0, 1);
        end
      end
      REQ_LIST: begin
        p = head_idx;
        steps = 0;
        k = 0;
        while (p < NSEG && steps < NSEG && k < NSEG) begin
          if (!sg_busy[p]) begin
            push_rsp(ST_FREE_SEG, sg_lo[p], sg_hi[p], 0, 0);
            k++;
          end
          p = sg_nxt[p];
          steps++;
        end
        if (k == 0) push_rsp(ST_NONE_FREE, 0, 0, 0, 1);
        else expected_rsps[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // monitor and prediction
  always @(posedge clk) begin
    alloc_rsp_t e;
    alloc_req_t q;
    in_acc <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) reset_pool(32'(cfg_pool_size));
      if (out_valid && out_ready) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result status=%0d addr=%0h", $realtime,
                     out_status, out_block_address);
        end else begin
          e = expected_rsps.pop_front();
          if (out_status !== e.status || out_block_address !== e.addr ||
              out_segment_end !== e.seg_end || out_issued_handle !== e.handle ||
              out_last_of_run !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp st=%0d a=%0h e=%0h h=%0d l=%0b got st=%0d a=%0h e=%0h h=%0d l=%0b",
                       $realtime, e.status, e.addr, e.seg_end, e.handle, e.last,
                       out_status, out_block_address, out_segment_end,
                       out_issued_handle, out_last_of_run);
          end
        end
      end
      if (in_valid && in_ready) begin
        q.kind = in_req_type; q.size = in_alloc_size; q.handle = in_free_handle;
        predict_request(q);
        reqs_taken++;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    alloc_req_t q;
    logic v;
    v = in_valid;
    if (rst_n && !(in_valid && !in_acc)) begin
      v = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        v = 1'b1;
        in_req_type <= q.kind;
        in_alloc_size <= q.size;
        in_free_handle <= q.handle;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 19);
      end
    end
    in_valid <= v;
  end

  // result stall
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 19);
    end
  end

  function automatic void add_req(logic [1:0] k, int unsigned s, int unsigned h);
    alloc_req_t q;
    q.kind = k; q.size = s[23:0]; q.handle = h[11:0];
    pending_reqs.push_back(q);
    if (k == REQ_ALLOC && gen_issued < NHND - 1) gen_issued++;
  endfunction

  function automatic void add_random(int n, int unsigned pool);
    int unsigned r, sz;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        case ($urandom_range(0, 7))
          0: sz = $urandom_range(0, 24'hFFFFFF);
          1: sz = 0;
          2: sz = pool;
          default: sz = $urandom_range(1, pool / 6 + 1);
        endcase
        add_req(REQ_ALLOC, sz, 0);
      end else if (r < 80) begin
        // mostly handles that were issued, some random
        if (gen_issued > 0 && $urandom_range(0, 4) != 0)
          add_req(REQ_FREE, 0, $urandom_range(1, gen_issued));
        else
          add_req(REQ_FREE, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, NHND - 1));
      end else if (r < 95) begin
        add_req(REQ_LIST, 0, 0);
      end else begin
        add_req(2'd3, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, NHND - 1));
      end
    end
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_pool(int unsigned len);
    @(negedge clk);
    cfg_pool_size <= len[23:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_issued = 0;
  endtask

  initial begin
    int unsigned sizes [5];
    reset_pool(POOL_RESET);
    gen_issued = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners on the reset pool
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_ALLOC, POOL_RESET, 0);
    add_req(REQ_LIST, 0, 0);
    add_req(REQ_ALLOC, 24'hFFFFFF, 0);
    add_req(REQ_FREE, 0, 0);
    add_req(REQ_FREE, 0, 1);
    add_req(REQ_FREE, 0, 2);
    add_req(REQ_FREE, 0, 2);
    add_req(REQ_FREE, 24'hFFFFFF, 12'hFFF);
    add_req(2'd3, 24'hFFFFFF, 12'hFFF);
    add_req(REQ_ALLOC, 100, 0);
    add_req(REQ_ALLOC, 200, 0);
    add_req(REQ_ALLOC, 300, 0);
    add_req(REQ_FREE, 0, 6);
    add_req(REQ_FREE, 0, 5);
    add_req(REQ_LIST, 0, 0);
    add_req(REQ_FREE, 0, 7);
    add_req(REQ_LIST, 0, 0);
    add_random(60, POOL_RESET);
    drain();

    // exhaust the segment table, then fragment it for a long listing
    write_pool(4096);
    for (int i = 0; i < 34; i++) add_req(REQ_ALLOC, 1, 0);
    for (int i = 1; i <= 33; i += 2) add_req(REQ_FREE, 0, i);
    add_req(REQ_LIST, 0, 0);
    add_random(40, 4096);
    drain();

    sizes[0] = 1; sizes[1] = 24'hFFFFFF; sizes[2] = 0;
    sizes[3] = $urandom_range(2, 24'hFFFFFF); sizes[4] = 500;
    for (int ph = 0; ph < 5; ph++) begin
      write_pool(sizes[ph]);
      add_req(REQ_LIST, 0, 0);
      if (ph == 4) quiet = 1'b1;
      add_random(26, sizes[ph]);
      drain();
    end

    $display("Covered %0d requests and %0d results over 7 pool settings,", reqs_taken,
             rsp_seen);
    $display("including full segment table, long listing and empty pool.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: first_fit_segment_allocator.f
rtl/ffsa_pkg.sv
rtl/first_fit_segment_allocator.sv
tb/sv/tb_first_fit_segment_allocator.sv
